// ===== rtl/core/oscp_pkg.sv =====
`timescale 1ns / 1ps

package oscp_pkg;

  // default bound on the option value length in bytes
  localparam int unsigned MaxOptionLength = 255;

  // flag byte layout: 0b000hknnn
  localparam int unsigned CtxFlagBit = 4;
  localparam int unsigned KidFlagBit = 3;
  localparam int unsigned PivLenMsb  = 2;

  // configuration register indexes (byte address / 4)
  localparam logic [1:0] RegPivCap = 2'd0;
  localparam logic [1:0] RegKidCap = 2'd1;
  localparam logic [1:0] RegCtxCap = 2'd2;

  // parser phase, also the section tag of the word being parsed
  typedef enum logic [2:0] {
    PH_FLAG   = 3'd0,
    PH_PIV    = 3'd1,
    PH_CTXLEN = 3'd2,
    PH_CTX    = 3'd3,
    PH_KID    = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_OPT_LEN = 3'd1,
    ST_PIV_LEN = 3'd2,
    ST_KID_LEN = 3'd3,
    ST_CTX_LEN = 3'd4
  } status_e;

  // one result word
  typedef struct packed {
    logic [2:0] section;
    logic [7:0] byte_out;
    logic [7:0] position;
    logic       done_res;
    status_e    status;
    logic [2:0] piv_length;
    logic [7:0] context_length;
    logic [7:0] kid_length;
    logic       kid_flag;
    logic       context_flag;
  } result_t;

endpackage

// ===== rtl/core/oscore_option_parser_top.sv =====
`timescale 1ns / 1ps
// a result word is registered into the output register when its byte is taken, or into the skid register instead
// while the output register holds a word not yet taken; throughput: one byte per cycle while in_stall_o is low
// a one-word skid register behind the output register keeps input open while a result waits
// reset (rst_ni low, asynchronous) returns the parser to expecting a flag byte,
// empties the output and skid registers and loads the capacities with 7, 255 and 255
module oscore_option_parser_top #(
  parameter int unsigned MAX_OPTION_LENGTH = oscp_pkg::MaxOptionLength
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // apb configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_i,
  input  logic        empty_option_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  section_o,
  output logic [7:0]  byte_out_o,
  output logic [7:0]  position_o,
  output logic        done_res_o,
  output logic [2:0]  status_o,
  output logic [2:0]  piv_length_o,
  output logic [7:0]  context_length_o,
  output logic [7:0]  kid_length_o,
  output logic        kid_flag_o,
  output logic        context_flag_o
);
  import oscp_pkg::*;

  localparam int unsigned TotW = $clog2(MAX_OPTION_LENGTH + 1);
  localparam logic [TotW-1:0] TotMax = TotW'(MAX_OPTION_LENGTH);

  // configuration registers
  logic [2:0] piv_cap_q;
  logic [7:0] kid_cap_q;
  logic [7:0] ctx_cap_q;
  logic       cfg_wr;

  // parser state
  phase_e          phase_q, phase_d;
  logic            ctx_bit_q, ctx_bit_d;
  logic            kid_bit_q, kid_bit_d;
  logic [2:0]      iv_len_q, iv_len_d;
  logic [7:0]      ctx_len_q, ctx_len_d;
  logic [7:0]      sect_cnt_q, sect_cnt_d;
  logic [7:0]      kid_cnt_q, kid_cnt_d;
  logic [TotW-1:0] tot_cnt_q, tot_cnt_d;
  logic            ovf_q, ovf_d;
  logic [7:0]      sect_inc;

  // output and skid registers
  result_t res_d;
  result_t out_q;
  result_t skid_q;
  logic    out_valid_q;
  logic    skid_valid_q;
  logic    in_acc;
  logic    out_acc;

  // apb register access
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    unique case (paddr[3:2])
      RegPivCap: prdata = {29'd0, piv_cap_q};
      RegKidCap: prdata = {24'd0, kid_cap_q};
      RegCtxCap: prdata = {24'd0, ctx_cap_q};
      default:   prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      piv_cap_q <= 3'd7;
      kid_cap_q <= 8'hFF;
      ctx_cap_q <= 8'hFF;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        RegPivCap: piv_cap_q <= pwdata[2:0];
        RegKidCap: kid_cap_q <= pwdata[7:0];
        RegCtxCap: ctx_cap_q <= pwdata[7:0];
        default:   ;
      endcase
    end
  end

  // handshakes
  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i & ~skid_valid_q;
  assign out_acc    = out_valid_q & ~out_stall_i;
  assign sect_inc   = sect_cnt_q + 8'd1;

  // next parser state and result word
  always_comb begin
    phase_d    = phase_q;
    ctx_bit_d  = ctx_bit_q;
    kid_bit_d  = kid_bit_q;
    iv_len_d   = iv_len_q;
    ctx_len_d  = ctx_len_q;
    sect_cnt_d = sect_cnt_q;
    kid_cnt_d  = kid_cnt_q;
    tot_cnt_d  = tot_cnt_q;
    ovf_d      = ovf_q;
    res_d      = '0;

    if (empty_option_i) begin
      // zero-length option abandons anything in progress
      phase_d    = PH_FLAG;
      ctx_bit_d  = 1'b0;
      kid_bit_d  = 1'b0;
      iv_len_d   = 3'd0;
      ctx_len_d  = 8'd0;
      sect_cnt_d = 8'd0;
      kid_cnt_d  = 8'd0;
      tot_cnt_d  = '0;
      ovf_d      = 1'b0;
      res_d.done_res = 1'b1;
      res_d.status   = ST_OPT_LEN;
    end else begin
      // saturating option length
      if (tot_cnt_q >= TotMax) ovf_d = 1'b1;
      else                     tot_cnt_d = tot_cnt_q + TotW'(1);

      res_d.byte_out = data_byte_i;

      unique case (phase_q)
        PH_PIV: begin
          res_d.section  = 3'(PH_PIV);
          res_d.position = sect_cnt_q;
          if (sect_inc >= {5'd0, iv_len_q}) begin
            sect_cnt_d = 8'd0;
            phase_d    = ctx_bit_q ? PH_CTXLEN : PH_KID;
          end else begin
            sect_cnt_d = sect_inc;
          end
        end
        PH_CTXLEN: begin
          res_d.section  = 3'(PH_CTXLEN);
          res_d.position = 8'd0;
          ctx_len_d      = data_byte_i;
          sect_cnt_d     = 8'd0;
          phase_d        = (data_byte_i != 8'd0) ? PH_CTX : PH_KID;
        end
        PH_CTX: begin
          res_d.section  = 3'(PH_CTX);
          res_d.position = sect_cnt_q;
          if (sect_inc >= ctx_len_q) begin
            sect_cnt_d = 8'd0;
            phase_d    = PH_KID;
          end else begin
            sect_cnt_d = sect_inc;
          end
        end
        PH_KID: begin
          res_d.section  = 3'(PH_KID);
          res_d.position = kid_cnt_q;
          if (kid_cnt_q == 8'hFF) ovf_d = 1'b1;
          else                    kid_cnt_d = kid_cnt_q + 8'd1;
        end
        default: begin
          // flag byte, reserved top bits ignored
          res_d.section  = 3'(PH_FLAG);
          res_d.position = 8'd0;
          ctx_bit_d      = data_byte_i[CtxFlagBit];
          kid_bit_d      = data_byte_i[KidFlagBit];
          iv_len_d       = data_byte_i[PivLenMsb:0];
          ctx_len_d      = 8'd0;
          sect_cnt_d     = 8'd0;
          kid_cnt_d      = 8'd0;
          if (data_byte_i[PivLenMsb:0] != 3'd0)  phase_d = PH_PIV;
          else if (data_byte_i[CtxFlagBit])      phase_d = PH_CTXLEN;
          else                                   phase_d = PH_KID;
        end
      endcase

      // end of option: report lengths and status, then start over
      if (last_i) begin
        priority if (ovf_d || phase_d != PH_KID) res_d.status = ST_OPT_LEN;
        else if (iv_len_d > piv_cap_q)           res_d.status = ST_PIV_LEN;
        else if (kid_cnt_d > kid_cap_q)          res_d.status = ST_KID_LEN;
        else if (ctx_len_d > ctx_cap_q)          res_d.status = ST_CTX_LEN;
        else                                     res_d.status = ST_OK;
        res_d.done_res       = 1'b1;
        res_d.piv_length     = iv_len_d;
        res_d.context_length = ctx_len_d;
        res_d.kid_length     = kid_cnt_d;
        res_d.kid_flag       = kid_bit_d;
        res_d.context_flag   = ctx_bit_d;
        phase_d    = PH_FLAG;
        ctx_bit_d  = 1'b0;
        kid_bit_d  = 1'b0;
        iv_len_d   = 3'd0;
        ctx_len_d  = 8'd0;
        sect_cnt_d = 8'd0;
        kid_cnt_d  = 8'd0;
        tot_cnt_d  = '0;
        ovf_d      = 1'b0;
      end
    end
  end

  // parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_FLAG;
      ctx_bit_q  <= 1'b0;
      kid_bit_q  <= 1'b0;
      iv_len_q   <= 3'd0;
      ctx_len_q  <= 8'd0;
      sect_cnt_q <= 8'd0;
      kid_cnt_q  <= 8'd0;
      tot_cnt_q  <= '0;
      ovf_q      <= 1'b0;
    end else if (in_acc) begin
      phase_q    <= phase_d;
      ctx_bit_q  <= ctx_bit_d;
      kid_bit_q  <= kid_bit_d;
      iv_len_q   <= iv_len_d;
      ctx_len_q  <= ctx_len_d;
      sect_cnt_q <= sect_cnt_d;
      kid_cnt_q  <= kid_cnt_d;
      tot_cnt_q  <= tot_cnt_d;
      ovf_q      <= ovf_d;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (in_acc) begin
      if (!out_valid_q || out_acc) out_valid_q <= 1'b1;
      else                         skid_valid_q <= 1'b1;
    end else if (out_acc) begin
      out_valid_q  <= skid_valid_q;
      skid_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (!out_valid_q || out_acc) out_q  <= res_d;
      else                         skid_q <= res_d;
    end else if (out_acc && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

  // output ports
  assign out_valid_o      = out_valid_q;
  assign section_o        = out_q.section;
  assign byte_out_o       = out_q.byte_out;
  assign position_o       = out_q.position;
  assign done_res_o       = out_q.done_res;
  assign status_o         = out_q.status;
  assign piv_length_o     = out_q.piv_length;
  assign context_length_o = out_q.context_length;
  assign kid_length_o     = out_q.kid_length;
  assign kid_flag_o       = out_q.kid_flag;
  assign context_flag_o   = out_q.context_flag;

  // checks
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid word held while output register empty");

  a_status_only_on_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.done_res) |-> (out_q.status == ST_OK))
    else $error("status set on a word that does not end the option");

  a_restart_after_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (last_i || empty_option_i)) |=> (phase_q == PH_FLAG && tot_cnt_q == '0))
    else $error("parser not back to flag byte after end of option");

  a_total_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tot_cnt_q <= TotMax)
    else $error("option length count beyond its bound");

endmodule

// ===== tb/tb_oscore_option_parser_top.sv =====
`timescale 1ns / 1ps

module tb_oscore_option_parser_top;
  import oscp_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned ItemsPerRound = 265;
  localparam int unsigned Rounds = 6;

  // one row of the directed script
  typedef struct packed {
    logic [7:0] b;
    logic       l;
    logic       e;
    logic       fixed;
    status_e    st;
    logic [2:0] piv;
    logic       kf;
    logic       cf;
  } step_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = '0;
  logic        last_i = 1'b0;
  logic        empty_option_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  section_o;
  logic [7:0]  byte_out_o;
  logic [7:0]  position_o;
  logic        done_res_o;
  logic [2:0]  status_o;
  logic [2:0]  piv_length_o;
  logic [7:0]  context_length_o;
  logic [7:0]  kid_length_o;
  logic        kid_flag_o;
  logic        context_flag_o;

  // parser state as the checker sees it
  phase_e      prs_phase = PH_FLAG;
  logic        prs_ctx_bit = 1'b0;
  logic        prs_kid_bit = 1'b0;
  logic [2:0]  prs_iv_len = '0;
  int unsigned prs_ctx_len = 0;
  int unsigned prs_sec_cnt = 0;
  int unsigned prs_kid_cnt = 0;
  int unsigned prs_total = 0;
  logic        prs_overflow = 1'b0;
  logic [2:0]  cap_piv = 3'd7;
  logic [7:0]  cap_kid = 8'd255;
  logic [7:0]  cap_ctx = 8'd255;

  result_t     tagged_q[$];
  step_t       script_q[$];
  int unsigned sent_cnt = 0;
  int unsigned errors = 0;
  int unsigned cycle_cnt = 0;
  int unsigned hold_left = 0;
  logic        calm = 1'b0;
  logic        hold_req = 1'b0;

  oscore_option_parser_top uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .last_i           (last_i),
    .empty_option_i   (empty_option_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .section_o        (section_o),
    .byte_out_o       (byte_out_o),
    .position_o       (position_o),
    .done_res_o       (done_res_o),
    .status_o         (status_o),
    .piv_length_o     (piv_length_o),
    .context_length_o (context_length_o),
    .kid_length_o     (kid_length_o),
    .kid_flag_o       (kid_flag_o),
    .context_flag_o   (context_flag_o)
  );

  always #4 clk_i = ~clk_i;

  // abandon the option in progress, expect a flag byte next
  function automatic void drop_option();
    prs_phase = PH_FLAG;
    prs_ctx_bit = 1'b0;
    prs_kid_bit = 1'b0;
    prs_iv_len = '0;
    prs_ctx_len = 0;
    prs_sec_cnt = 0;
    prs_kid_cnt = 0;
    prs_total = 0;
    prs_overflow = 1'b0;
  endfunction

  // tag one byte and advance the parser state
  function automatic result_t tag_byte(logic [7:0] b, logic l, logic e);
    result_t     r;
    phase_e      sec;
    int unsigned pos;
    r = '0;
    sec = PH_FLAG;
    pos = 0;
    if (e) begin
      drop_option();
      r.done_res = 1'b1;
      r.status = ST_OPT_LEN;
      return r;
    end
    if (prs_total >= MaxOptionLength) prs_overflow = 1'b1;
    else prs_total++;
    case (prs_phase)
      PH_PIV: begin
        sec = PH_PIV;
        pos = prs_sec_cnt;
        prs_sec_cnt++;
        if (prs_sec_cnt >= prs_iv_len) begin
          prs_sec_cnt = 0;
          prs_phase = prs_ctx_bit ? PH_CTXLEN : PH_KID;
        end
      end
      PH_CTXLEN: begin
        sec = PH_CTXLEN;
        prs_ctx_len = b;
        prs_sec_cnt = 0;
        prs_phase = (b != 0) ? PH_CTX : PH_KID;
      end
      PH_CTX: begin
        sec = PH_CTX;
        pos = prs_sec_cnt;
        prs_sec_cnt++;
        if (prs_sec_cnt >= prs_ctx_len) begin
          prs_sec_cnt = 0;
          prs_phase = PH_KID;
        end
      end
      PH_KID: begin
        sec = PH_KID;
        pos = prs_kid_cnt;
        if (prs_kid_cnt >= 255) prs_overflow = 1'b1;
        else prs_kid_cnt++;
      end
      default: begin
        prs_ctx_bit = b[CtxFlagBit];
        prs_kid_bit = b[KidFlagBit];
        prs_iv_len = b[PivLenMsb:0];
        prs_ctx_len = 0;
        prs_sec_cnt = 0;
        prs_kid_cnt = 0;
        if (prs_iv_len != 0) prs_phase = PH_PIV;
        else prs_phase = prs_ctx_bit ? PH_CTXLEN : PH_KID;
      end
    endcase
    r.section = sec;
    r.byte_out = b;
    r.position = 8'(pos);
    // closing word carries the lengths and the status
    if (l) begin
      if (prs_overflow || prs_phase != PH_KID) r.status = ST_OPT_LEN;
      else if (prs_iv_len > cap_piv) r.status = ST_PIV_LEN;
      else if (prs_kid_cnt > cap_kid) r.status = ST_KID_LEN;
      else if (prs_ctx_len > cap_ctx) r.status = ST_CTX_LEN;
      else r.status = ST_OK;
      r.done_res = 1'b1;
      r.piv_length = prs_iv_len;
      r.context_length = 8'(prs_ctx_len);
      r.kid_length = 8'(prs_kid_cnt);
      r.kid_flag = prs_kid_bit;
      r.context_flag = prs_ctx_bit;
      drop_option();
    end
    return r;
  endfunction

  function automatic void add_step(logic [7:0] b, logic l, logic e, logic fixed,
                                   status_e st, logic [2:0] piv, logic kf, logic cf);
    step_t s;
    s.b = b;
    s.l = l;
    s.e = e;
    s.fixed = fixed;
    s.st = st;
    s.piv = piv;
    s.kf = kf;
    s.cf = cf;
    script_q.push_back(s);
  endfunction

  // register write: setup cycle, access cycle, then idle
  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      RegPivCap: cap_piv = val[2:0];
      RegKidCap: cap_kid = val[7:0];
      RegCtxCap: cap_ctx = val[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
  endtask

  // offer one word, entered and left at a falling edge
  task automatic send_word(input logic [7:0] b, input logic l, input logic e,
                           input logic fixed, input result_t fixed_res);
    result_t r;
    while (!calm && $urandom_range(99) < 17) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    last_i <= l;
    empty_option_i <= e;
    do @(posedge clk_i); while (in_stall_o);
    r = tag_byte(b, l, e);
    tagged_q.push_back(fixed ? fixed_res : r);
    sent_cnt++;
    @(negedge clk_i);
  endtask

  // hold input back until every expected word has come out
  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (tagged_q.size() != 0) @(negedge clk_i);
  endtask

  // one random option: mostly well formed, some truncated, abandoned or noise
  task automatic send_option();
    logic [7:0]  body[$];
    int unsigned roll;
    int unsigned iv;
    int unsigned ctx_n;
    int unsigned kid_n;
    int unsigned cut;
    logic        ctx_f;
    roll = $urandom_range(99);
    if (roll < 3) begin
      cut = $urandom_range(1, 6);
      for (int i = 0; i < cut; i++)
        send_word(8'($urandom), i == cut - 1, 1'b0, 1'b0, '0);
      return;
    end
    iv = $urandom_range(0, 7);
    ctx_f = 1'($urandom);
    body.push_back({3'($urandom), ctx_f, 1'($urandom), 3'(iv)});
    repeat (iv) body.push_back(8'($urandom));
    if (ctx_f) begin
      ctx_n = ($urandom_range(99) < 4) ? $urandom_range(0, 255) : $urandom_range(0, 6);
      body.push_back(8'(ctx_n));
      repeat (ctx_n) body.push_back(8'($urandom));
    end
    kid_n = ($urandom_range(99) < 3) ? $urandom_range(200, 300) : $urandom_range(0, 8);
    repeat (kid_n) body.push_back(8'($urandom));
    if (roll < 13) begin
      // truncated somewhere inside
      cut = $urandom_range(1, body.size());
      for (int i = 0; i < cut; i++) send_word(body[i], i == cut - 1, 1'b0, 1'b0, '0);
    end else if (roll < 20) begin
      // abandoned by an empty option
      cut = $urandom_range(0, body.size() - 1);
      for (int i = 0; i < cut; i++) send_word(body[i], 1'b0, 1'b0, 1'b0, '0);
      send_word(8'($urandom), 1'($urandom), 1'b1, 1'b0, '0);
    end else begin
      foreach (body[i]) send_word(body[i], i == body.size() - 1, 1'b0, 1'b0, '0);
    end
  endtask

  // receiver: random stalls, or a long hold when asked
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 80;
    end
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < 17);
    end
  end

  // compare each word taken from the output with the oldest expectation
  always @(posedge clk_i) begin : word_check
    result_t got;
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.section = section_o;
      got.byte_out = byte_out_o;
      got.position = position_o;
      got.done_res = done_res_o;
      got.status = status_e'(status_o);
      got.piv_length = piv_length_o;
      got.context_length = context_length_o;
      got.kid_length = kid_length_o;
      got.kid_flag = kid_flag_o;
      got.context_flag = context_flag_o;
      if (tagged_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word: byte %02h sec %0d", byte_out_o, section_o);
      end else begin
        want = tagged_q.pop_front();
        if (got.section !== want.section || got.byte_out !== want.byte_out ||
            got.position !== want.position || got.done_res !== want.done_res ||
            got.status !== want.status || got.piv_length !== want.piv_length ||
            got.context_length !== want.context_length ||
            got.kid_length !== want.kid_length || got.kid_flag !== want.kid_flag ||
            got.context_flag !== want.context_flag) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch exp: sec %0d byte %02h pos %0d done %0b st %0d",
                     want.section, want.byte_out, want.position, want.done_res, want.status,
                     " piv %0d ctx %0d kid %0d kf %0b cf %0b",
                     want.piv_length, want.context_length, want.kid_length, want.kid_flag,
                     want.context_flag);
            $display("         got: sec %0d byte %02h pos %0d done %0b st %0d",
                     got.section, got.byte_out, got.position, got.done_res, got.status,
                     " piv %0d ctx %0d kid %0d kf %0b cf %0b",
                     got.piv_length, got.context_length, got.kid_length, got.kid_flag,
                     got.context_flag);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    result_t fixed_res;
    logic    paused;
    paused = 1'b0;

    // directed script; fixed rows carry a hand-written closing word
    // empty option, data ignored
    add_step(8'hA5, 1'b0, 1'b1, 1'b1, ST_OPT_LEN, 3'd0, 1'b0, 1'b0);
    // flag byte alone: no partial iv, no context, empty kid
    add_step(8'h00, 1'b1, 1'b0, 1'b1, ST_OK, 3'd0, 1'b0, 1'b0);
    // all flag bits set, cut short in the partial iv
    add_step(8'hFF, 1'b1, 1'b0, 1'b1, ST_OPT_LEN, 3'd7, 1'b1, 1'b1);
    // kid flag is only reported
    add_step(8'h08, 1'b1, 1'b0, 1'b1, ST_OK, 3'd0, 1'b1, 1'b0);
    // reserved bits ignored
    add_step(8'hE0, 1'b1, 1'b0, 1'b1, ST_OK, 3'd0, 1'b0, 1'b0);
    // context flag, cut short before the length word
    add_step(8'h10, 1'b1, 1'b0, 1'b1, ST_OPT_LEN, 3'd0, 1'b0, 1'b1);
    // full option: three iv words, context of two, kid of two
    add_step(8'h13, 1'b0, 1'b0, 1'b0, ST_OK, 3'd0, 1'b0, 1'b0);
    add_step(8'hAA, 1'b0, 1'b0, 1'b0, ST_OK, 3'd0, 1'b0, 1'b0);
    add_step(8'hBB, 1'b0, 1'b0, 1'b0, ST_OK, 3'd0, 1'b0, 1'b0);
    add_step(8'hCC, 1'b0, 1'b0, 1'b0, ST_OK, 3'd0, 1'b0, 1'b0);
    add_step(8'h02, 1'b0, 1'b0, 1'b0, ST_OK, 3'd0, 1'b0, 1'b0);
    add_step(8'h11, 1'b0, 1'b0, 1'b0, ST_OK, 3'd0, 1'b0, 1'b0);
    add_step(8'h22, 1'b0, 1'b0, 1'b0, ST_OK, 3'd0, 1'b0, 1'b0);
    add_step(8'h01, 1'b0, 1'b0, 1'b0, ST_OK, 3'd0, 1'b0, 1'b0);
    add_step(8'h02, 1'b1, 1'b0, 1'b0, ST_OK, 3'd0, 1'b0, 1'b0);
    // zero context length goes straight to the kid
    add_step(8'h10, 1'b0, 1'b0, 1'b0, ST_OK, 3'd0, 1'b0, 1'b0);
    add_step(8'h00, 1'b0, 1'b0, 1'b0, ST_OK, 3'd0, 1'b0, 1'b0);
    add_step(8'hFF, 1'b1, 1'b0, 1'b0, ST_OK, 3'd0, 1'b0, 1'b0);
    // cut short inside the context
    add_step(8'h11, 1'b0, 1'b0, 1'b0, ST_OK, 3'd0, 1'b0, 1'b0);
    add_step(8'h55, 1'b0, 1'b0, 1'b0, ST_OK, 3'd0, 1'b0, 1'b0);
    add_step(8'h03, 1'b0, 1'b0, 1'b0, ST_OK, 3'd0, 1'b0, 1'b0);
    add_step(8'h01, 1'b1, 1'b0, 1'b0, ST_OK, 3'd0, 1'b0, 1'b0);
    // empty option abandons the one in progress
    add_step(8'h02, 1'b0, 1'b0, 1'b0, ST_OK, 3'd0, 1'b0, 1'b0);
    add_step(8'h09, 1'b0, 1'b0, 1'b0, ST_OK, 3'd0, 1'b0, 1'b0);
    add_step(8'h00, 1'b0, 1'b1, 1'b1, ST_OPT_LEN, 3'd0, 1'b0, 1'b0);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (script_q[i]) begin
      fixed_res = '0;
      fixed_res.section = PH_FLAG;
      fixed_res.byte_out = script_q[i].e ? 8'h00 : script_q[i].b;
      fixed_res.done_res = 1'b1;
      fixed_res.status = script_q[i].st;
      fixed_res.piv_length = script_q[i].piv;
      fixed_res.kid_flag = script_q[i].kf;
      fixed_res.context_flag = script_q[i].cf;
      send_word(script_q[i].b, script_q[i].l, script_q[i].e, script_q[i].fixed, fixed_res);
    end

    // random rounds, each under its own capacity setting
    for (int rnd = 0; rnd < Rounds; rnd++) begin
      drain();
      case (rnd)
        0: begin
          apb_write(RegPivCap, 32'd7);
          apb_write(RegKidCap, 32'd255);
          apb_write(RegCtxCap, 32'd255);
        end
        1: begin
          apb_write(RegPivCap, 32'd0);
          apb_write(RegKidCap, 32'd0);
          apb_write(RegCtxCap, 32'd0);
        end
        2: begin
          apb_write(RegPivCap, 32'd3);
          apb_write(RegKidCap, 32'd4);
          apb_write(RegCtxCap, 32'd2);
        end
        default: begin
          apb_write(RegPivCap, $urandom_range(0, 7));
          apb_write(RegKidCap,
                    $urandom_range(1) ? $urandom_range(0, 10) : $urandom_range(0, 255));
          apb_write(RegCtxCap,
                    $urandom_range(1) ? $urandom_range(0, 6) : $urandom_range(0, 255));
        end
      endcase
      calm = (rnd == 1);
      if (rnd == 2) hold_req = 1'b1;
      while (sent_cnt < script_q.size() + (rnd + 1) * ItemsPerRound) begin
        // sender waits for the output to run dry once, mid-round
        if (rnd == 3 && !paused && sent_cnt >= script_q.size() + 3 * ItemsPerRound + 100) begin
          paused = 1'b1;
          drain();
        end
        send_option();
      end
    end

    drain();
    repeat (4) @(posedge clk_i);
    if (tagged_q.size() != 0) errors++;
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
